// ===== rtl/tkrg_pkg.sv =====
// ----------------------------------------------------------------------------
// tkrg_pkg
// shared types and constants for the tile keyframe recovery gate
// ----------------------------------------------------------------------------
package tkrg_pkg;

	localparam int TIME_W = 63;
	localparam int WIN_W = 40;
	localparam int CAP_W = 16;
	localparam int STREAK_W = 16;
	localparam int CYCLE_W = 8;
	localparam int FLICK_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 40;
	localparam int TILE_W = 8;
	localparam logic [CYCLE_W-1:0] REPEAT_CYCLE_LIMIT = 8'd3;

	typedef enum logic [2:0] {
		ACT_ERROR = 3'd0,
		ACT_IDR = 3'd1,
		ACT_CLEAN = 3'd2,
		ACT_POLL = 3'd3,
		ACT_FORCE_ALL = 3'd4,
		ACT_RESET_ALL = 3'd5,
		ACT_RESET_TILE = 3'd6,
		ACT_NONE = 3'd7
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IDR_GRACE = 3'd0,
		CFG_QUIET = 3'd1,
		CFG_CAP = 3'd2,
		CFG_INTERVAL = 3'd3,
		CFG_SLOW_INTERVAL = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		action_t action;
		logic [TILE_W-1:0] tile;
		logic [TIME_W-1:0] timestamp;
		logic reliable_error;
		logic suspicious_idr;
	} req_t;

	typedef struct packed {
		logic request_keyframe;
		logic slow_backoff_warning;
		logic repeat_cycle_warning;
		logic tile_needs_keyframe;
		logic [STREAK_W-1:0] tile_error_streak;
		logic tile_needs_real_frame;
		logic any_needs_keyframe;
		logic [FLICK_W-1:0] flicker_total;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic capture;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;
	} sts_t;

	function automatic logic below(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] then, input logic [WIN_W-1:0] win);
		logic [TIME_W-1:0] d;
		begin
			d = now - then;
			below = (now < then) || (d < {{(TIME_W-WIN_W){1'b0}}, win});
		end
	endfunction

endpackage

// ===== rtl/tkrg_if.sv =====
// ----------------------------------------------------------------------------
// tkrg_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface tkrg_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tile_keyframe_recovery_gate_core.sv =====
// per-tile actions and polls: accept, execute, result
// force-all and reset-all: accept, execute sweeping one tile per cycle, result
// throughput: one transaction at a time; next accepted the cycle after the result is taken
// reset: arst_n clears all tile state and counters and loads the register defaults
// ----------------------------------------------------------------------------
// tile_keyframe_recovery_gate_core
// per-tile decode recovery tracking with rate-limited keyframe requests
// ----------------------------------------------------------------------------
module tile_keyframe_recovery_gate_core
	import tkrg_pkg::*;
#(
	parameter int TILE_COUNT = 16
) (
	input logic clk,
	input logic arst_n,
	tkrg_if.sink req,
	tkrg_if.source rsp,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;
	rsp_t rsp_d;

	tkrg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd), .sts(sts)
	);

	tkrg_dp #(.TILE_COUNT(TILE_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req.data), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .rsp(rsp_d)
	);

	assign rsp.data = rsp_d;

endmodule

// ===== rtl/tkrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkrg_ctrl
// controller: accept, execute (sweep for bulk actions), present result
// ----------------------------------------------------------------------------
module tkrg_ctrl
	import tkrg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output cmd_t cmd,
	input sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_OUT = 3'b100
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cmd.load = in_valid && in_ready;
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.capture = cmd.exec && sts.sweep_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_EXEC;
				ST_EXEC: if (sts.sweep_last) state_q <= ST_OUT;
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_out_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> out_valid) else $error("no result after execute");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
`endif

endmodule

// ===== rtl/tkrg_dp.sv =====
// ----------------------------------------------------------------------------
// tkrg_dp
// datapath: per-tile state, shared state and result register
// ----------------------------------------------------------------------------
module tkrg_dp
	import tkrg_pkg::*;
#(
	parameter int TILE_COUNT = 16
) (
	input logic clk,
	input logic arst_n,
	input req_t req,
	input cmd_t cmd,
	output sts_t sts,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output rsp_t rsp
);

	localparam int IW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;

	logic [WIN_W-1:0] grace_q, quiet_q, ival_q, slow_q;
	logic [CAP_W-1:0] cap_q;

	logic [TILE_COUNT-1:0] nk_q, seen_q, rfp_q, cw_q;
	logic [TIME_W-1:0] idr_t_q [TILE_COUNT];
	logic [STREAK_W-1:0] streak_q [TILE_COUNT];
	logic [CYCLE_W-1:0] cyc_q [TILE_COUNT];
	logic [CAP_W-1:0] att_q [TILE_COUNT];
	logic [TIME_W-1:0] last_req_q, last_unrel_q;
	logic [FLICK_W-1:0] flick_q;

	req_t req_q;
	logic [IW-1:0] idx_q;
	logic grant_q, slow_warn_q, cyc_warn_q;

	logic bulk, sweep_last, valid_t, err_en, unrel_en;
	logic [IW-1:0] ti;
	logic in_grace, new_flag;
	logic recover, capped, poll_ok;
	logic [WIN_W-1:0] win;

	assign bulk = (req_q.action == ACT_FORCE_ALL) || (req_q.action == ACT_RESET_ALL);
	assign sweep_last = !bulk || (idx_q == IW'(TILE_COUNT - 1));
	assign sts.sweep_last = sweep_last;
	assign valid_t = {1'b0, req_q.tile} < (TILE_W+1)'(TILE_COUNT);
	assign ti = bulk ? idx_q : req_q.tile[IW-1:0];
	assign err_en = cmd.exec && (req_q.action == ACT_FORCE_ALL ||
		(req_q.action == ACT_ERROR && valid_t));
	assign unrel_en = err_en && !req_q.reliable_error;
	assign in_grace = (idr_t_q[ti] != '0) &&
		below(req_q.timestamp, idr_t_q[ti], grace_q);
	assign new_flag = err_en && !in_grace && !nk_q[ti];
	assign recover = nk_q[ti] && seen_q[ti] &&
		!below(req_q.timestamp, last_unrel_q, quiet_q);
	assign capped = att_q[0] >= cap_q;
	assign win = capped ? slow_q : ival_q;
	assign poll_ok = (|nk_q) && !below(req_q.timestamp, last_req_q, win);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q <= WIN_W'(200000000);
			quiet_q <= WIN_W'(500000000);
			cap_q <= CAP_W'(5);
			ival_q <= WIN_W'(100000000);
			slow_q <= WIN_W'(64'd5000000000);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_IDR_GRACE: grace_q <= cfg_data;
				CFG_QUIET: quiet_q <= cfg_data;
				CFG_CAP: cap_q <= cfg_data[CAP_W-1:0];
				CFG_INTERVAL: ival_q <= cfg_data;
				CFG_SLOW_INTERVAL: slow_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			nk_q <= '0;
			seen_q <= '0;
			rfp_q <= '0;
			cw_q <= '0;
			last_req_q <= '0;
			last_unrel_q <= '0;
			flick_q <= '0;
			grant_q <= 1'b0;
			slow_warn_q <= 1'b0;
			cyc_warn_q <= 1'b0;
			for (int i = 0; i < TILE_COUNT; i++) begin
				idr_t_q[i] <= '0;
				streak_q[i] <= '0;
				cyc_q[i] <= '0;
				att_q[i] <= '0;
			end
		end else if (cmd.load) begin
			idx_q <= '0;
			grant_q <= 1'b0;
			slow_warn_q <= 1'b0;
			cyc_warn_q <= 1'b0;
		end else if (cmd.exec) begin
			idx_q <= sweep_last ? '0 : idx_q + 1'b1;
			if (unrel_en) last_unrel_q <= req_q.timestamp;
			if (err_en && !in_grace) begin
				if (streak_q[ti] != '1) streak_q[ti] <= streak_q[ti] + 1'b1;
				rfp_q[ti] <= 1'b1;
			end
			if (new_flag) begin
				nk_q[ti] <= 1'b1;
				seen_q[ti] <= 1'b0;
				att_q[ti] <= '0;
				cw_q[ti] <= 1'b0;
				if (flick_q != '1) flick_q <= flick_q + 1'b1;
				if (cyc_q[ti] != '1) cyc_q[ti] <= cyc_q[ti] + 1'b1;
			end
			case (req_q.action)
				ACT_IDR: if (valid_t) begin
					idr_t_q[ti] <= req_q.timestamp;
					if (!req_q.suspicious_idr && nk_q[ti]) seen_q[ti] <= 1'b1;
				end
				ACT_CLEAN: if (valid_t) begin
					streak_q[ti] <= '0;
					rfp_q[ti] <= 1'b0;
					if (recover) begin
						nk_q[ti] <= 1'b0;
						seen_q[ti] <= 1'b0;
						att_q[ti] <= '0;
						cw_q[ti] <= 1'b0;
						if (cyc_q[ti] >= REPEAT_CYCLE_LIMIT) begin
							cyc_warn_q <= 1'b1;
							cyc_q[ti] <= '0;
						end
					end
				end
				ACT_POLL: if (poll_ok) begin
					last_req_q <= req_q.timestamp;
					if (att_q[0] != '1) att_q[0] <= att_q[0] + 1'b1;
					if (capped && !cw_q[0]) begin
						slow_warn_q <= 1'b1;
						cw_q[0] <= 1'b1;
					end
					grant_q <= 1'b1;
				end
				ACT_RESET_ALL, ACT_RESET_TILE:
					if (req_q.action == ACT_RESET_ALL || valid_t) begin
						nk_q[ti] <= 1'b0;
						seen_q[ti] <= 1'b0;
						rfp_q[ti] <= 1'b0;
						cw_q[ti] <= 1'b0;
						idr_t_q[ti] <= '0;
						streak_q[ti] <= '0;
						cyc_q[ti] <= '0;
						att_q[ti] <= '0;
					end
				default: ;
			endcase
		end
	end

	logic [IW-1:0] oi;
	assign oi = req_q.tile[IW-1:0];
	assign rsp.request_keyframe = grant_q;
	assign rsp.slow_backoff_warning = slow_warn_q;
	assign rsp.repeat_cycle_warning = cyc_warn_q;
	assign rsp.tile_needs_keyframe = valid_t && nk_q[oi];
	assign rsp.tile_error_streak = valid_t ? streak_q[oi] : '0;
	assign rsp.tile_needs_real_frame = valid_t && rfp_q[oi];
	assign rsp.any_needs_keyframe = |nk_q;
	assign rsp.flicker_total = flick_q;

`ifndef ASSERT_OFF
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !bulk) |-> sweep_last) else $error("sweep on single-tile action");
	a_flick_mono: assert property (@(posedge clk) disable iff (!arst_n)
		flick_q >= $past(flick_q) || cmd.load) else $error("flicker count fell");
	a_grant_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && req_q.action == ACT_POLL && !(|nk_q)) |=> !grant_q)
		else $error("grant with no flagged tile");
`endif

endmodule

// ===== tb/sv/tile_keyframe_recovery_gate_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_keyframe_recovery_gate_core_tb
// drives event transactions through the recovery gate and checks every
// status response against a cycle-free model of the tile state, first from a
// table of directed events, then from random traffic under several register
// settings, with random gaps on the request side and random stalls on the
// response side
// ----------------------------------------------------------------------------
module tile_keyframe_recovery_gate_core_tb;
	import tkrg_pkg::*;

	localparam int NT = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE = NT + 8;

	typedef struct {
		req_t r;
		bit typed;
		rsp_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tkrg_if #(.T(req_t)) req_if();
	tkrg_if #(.T(rsp_t)) rsp_if();

	tile_keyframe_recovery_gate_core #(.TILE_COUNT(NT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// model of the tile state
	logic [WIN_W-1:0] grace_win, quiet_win, ivl_win, slow_win;
	logic [CAP_W-1:0] att_cap;
	logic nk [NT];
	logic seen [NT];
	logic [63:0] idr_ts [NT];
	logic [STREAK_W-1:0] streak [NT];
	logic rfp [NT];
	logic [CYCLE_W-1:0] cyc [NT];
	logic [15:0] att [NT];
	logic capw [NT];
	logic [63:0] last_req_ts, last_unrel_ts;
	logic [FLICK_W-1:0] flicks;

	rsp_t status_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int stall = 0;
	bit no_idle = 1'b0;

	function automatic bit too_soon(input logic [63:0] now, input logic [63:0] then,
			input logic [WIN_W-1:0] win);
		too_soon = (now < then) || ((now - then) < {24'd0, win});
	endfunction

	function automatic void clear_tile(input int t);
		nk[t] = 1'b0;
		seen[t] = 1'b0;
		idr_ts[t] = '0;
		streak[t] = '0;
		rfp[t] = 1'b0;
		cyc[t] = '0;
		att[t] = '0;
		capw[t] = 1'b0;
	endfunction

	function automatic void tile_error(input int t, input logic [63:0] now, input logic rel);
		if (!rel)
			last_unrel_ts = now;
		if (idr_ts[t] != 0 && too_soon(now, idr_ts[t], grace_win))
			return;
		if (streak[t] != 16'hFFFF)
			streak[t]++;
		rfp[t] = 1'b1;
		if (!nk[t]) begin
			nk[t] = 1'b1;
			seen[t] = 1'b0;
			att[t] = '0;
			capw[t] = 1'b0;
			if (flicks != 32'hFFFF_FFFF)
				flicks++;
			if (cyc[t] != 8'hFF)
				cyc[t]++;
		end
	endfunction

	function automatic bit any_flagged();
		any_flagged = 1'b0;
		for (int i = 0; i < NT; i++)
			if (nk[i])
				any_flagged = 1'b1;
	endfunction

	function automatic rsp_t gate_status(input req_t r);
		rsp_t o;
		logic [63:0] now;
		bit ok, capped;
		int t;
		logic [WIN_W-1:0] win;
		o = '0;
		now = {1'b0, r.timestamp};
		t = r.tile;
		ok = t < NT;
		case (r.action)
			ACT_ERROR: if (ok) tile_error(t, now, r.reliable_error);
			ACT_IDR: if (ok) begin
				idr_ts[t] = now;
				if (!r.suspicious_idr && nk[t])
					seen[t] = 1'b1;
			end
			ACT_CLEAN: if (ok) begin
				streak[t] = '0;
				rfp[t] = 1'b0;
				if (nk[t] && seen[t] && !too_soon(now, last_unrel_ts, quiet_win)) begin
					nk[t] = 1'b0;
					seen[t] = 1'b0;
					att[t] = '0;
					capw[t] = 1'b0;
					if (cyc[t] >= REPEAT_CYCLE_LIMIT) begin
						o.repeat_cycle_warning = 1'b1;
						cyc[t] = '0;
					end
				end
			end
			ACT_POLL: if (any_flagged()) begin
				capped = att[0] >= att_cap;
				win = capped ? slow_win : ivl_win;
				if (!too_soon(now, last_req_ts, win)) begin
					last_req_ts = now;
					if (att[0] != 16'hFFFF)
						att[0]++;
					if (capped && !capw[0]) begin
						o.slow_backoff_warning = 1'b1;
						capw[0] = 1'b1;
					end
					o.request_keyframe = 1'b1;
				end
			end
			ACT_FORCE_ALL: for (int i = 0; i < NT; i++) tile_error(i, now, r.reliable_error);
			ACT_RESET_ALL: for (int i = 0; i < NT; i++) clear_tile(i);
			ACT_RESET_TILE: if (ok) clear_tile(t);
			default: ;
		endcase
		if (ok) begin
			o.tile_needs_keyframe = nk[t];
			o.tile_error_streak = streak[t];
			o.tile_needs_real_frame = rfp[t];
		end
		o.any_needs_keyframe = any_flagged();
		o.flicker_total = flicks;
		return o;
	endfunction

	task automatic check_status(input rsp_t e, input rsp_t a);
		bit bad;
		bad = 1'b0;
		if (a.request_keyframe !== e.request_keyframe) begin
			$display("%0t request_keyframe exp %0d got %0d", $time,
				e.request_keyframe, a.request_keyframe);
			bad = 1'b1;
		end
		if (a.slow_backoff_warning !== e.slow_backoff_warning) begin
			$display("%0t slow_backoff_warning exp %0d got %0d", $time,
				e.slow_backoff_warning, a.slow_backoff_warning);
			bad = 1'b1;
		end
		if (a.repeat_cycle_warning !== e.repeat_cycle_warning) begin
			$display("%0t repeat_cycle_warning exp %0d got %0d", $time,
				e.repeat_cycle_warning, a.repeat_cycle_warning);
			bad = 1'b1;
		end
		if (a.tile_needs_keyframe !== e.tile_needs_keyframe) begin
			$display("%0t tile_needs_keyframe exp %0d got %0d", $time,
				e.tile_needs_keyframe, a.tile_needs_keyframe);
			bad = 1'b1;
		end
		if (a.tile_error_streak !== e.tile_error_streak) begin
			$display("%0t tile_error_streak exp %0d got %0d", $time,
				e.tile_error_streak, a.tile_error_streak);
			bad = 1'b1;
		end
		if (a.tile_needs_real_frame !== e.tile_needs_real_frame) begin
			$display("%0t tile_needs_real_frame exp %0d got %0d", $time,
				e.tile_needs_real_frame, a.tile_needs_real_frame);
			bad = 1'b1;
		end
		if (a.any_needs_keyframe !== e.any_needs_keyframe) begin
			$display("%0t any_needs_keyframe exp %0d got %0d", $time,
				e.any_needs_keyframe, a.any_needs_keyframe);
			bad = 1'b1;
		end
		if (a.flicker_total !== e.flicker_total) begin
			$display("%0t flicker_total exp %0d got %0d", $time,
				e.flicker_total, a.flicker_total);
			bad = 1'b1;
		end
		if (bad)
			errors++;
	endtask

	// response side: check and draw a stall per transaction
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (status_q.size() == 0) begin
				$display("%0t unexpected response exp none got %h", $time, rsp_if.data);
				errors++;
			end else begin
				check_status(status_q.pop_front(), rsp_if.data);
			end
			stall = no_idle ? 0 : $urandom_range(0, 3);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready = 1'b0;
		end else if (stall > 0) begin
			rsp_if.ready = 1'b0;
			stall--;
		end else begin
			rsp_if.ready = 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send(input req_t r, input bit typed, input rsp_t e);
		int gap;
		rsp_t p;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.data = r;
		do @(posedge clk); while (!req_if.ready);
		p = gate_status(r);
		status_q.push_back(typed ? e : p);
		@(negedge clk);
	endtask

	task automatic drain();
		req_if.valid = 1'b0;
		while (status_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_IDR_GRACE: grace_win = v;
			CFG_QUIET: quiet_win = v;
			CFG_CAP: att_cap = v[CAP_W-1:0];
			CFG_INTERVAL: ivl_win = v;
			CFG_SLOW_INTERVAL: slow_win = v;
			default: ;
		endcase
	endtask

	function automatic req_t mk(input action_t a, input int t, input logic [TIME_W-1:0] ts,
			input logic rel, input logic sus);
		req_t r;
		r.action = a;
		r.tile = TILE_W'(t);
		r.timestamp = ts;
		r.reliable_error = rel;
		r.suspicious_idr = sus;
		return r;
	endfunction

	function automatic rsp_t mk_status(input bit nkf, input int s, input bit rf,
			input bit anyf, input int fl);
		rsp_t o;
		o = '0;
		o.tile_needs_keyframe = nkf;
		o.tile_error_streak = STREAK_W'(s);
		o.tile_needs_real_frame = rf;
		o.any_needs_keyframe = anyf;
		o.flicker_total = FLICK_W'(fl);
		return o;
	endfunction

	logic [TIME_W-1:0] now_ts;

	task automatic random_phase(input int n, input logic [63:0] step_mask);
		req_t r;
		int k;
		logic [63:0] dt;
		action_t a;
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			k = $urandom_range(0, 99);
			a = k < 30 ? ACT_ERROR : k < 48 ? ACT_IDR : k < 66 ? ACT_CLEAN :
				k < 84 ? ACT_POLL : k < 88 ? ACT_FORCE_ALL : k < 91 ? ACT_RESET_ALL :
				k < 97 ? ACT_RESET_TILE : ACT_NONE;
			k = $urandom_range(0, 99);
			r.action = a;
			r.tile = TILE_W'(k < 85 ? $urandom_range(0, 3) :
				k < 95 ? $urandom_range(0, NT - 1) : $urandom_range(NT, 255));
			k = $urandom_range(0, 99);
			dt = {$urandom, $urandom} & step_mask;
			if (k < 3)
				now_ts = now_ts - dt[TIME_W-1:0];
			else if (k < 5)
				now_ts = TIME_W'({$urandom, $urandom});
			else
				now_ts = now_ts + dt[TIME_W-1:0];
			r.timestamp = now_ts;
			r.reliable_error = 1'($urandom_range(0, 1));
			r.suspicious_idr = ($urandom_range(0, 3) == 0);
			send(r, 1'b0, '0);
		end
		no_idle = 1'b0;
	endtask

	row_t dir [$];
	localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

	initial begin
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		grace_win = 40'd200000000;
		quiet_win = 40'd500000000;
		att_cap = 16'd5;
		ivl_win = 40'd100000000;
		slow_win = 40'd5000000000;
		for (int i = 0; i < NT; i++)
			clear_tile(i);
		last_req_ts = '0;
		last_unrel_ts = '0;
		flicks = '0;
		now_ts = '0;

		// after reset, extremes, ignored tiles and the first errors on tile 0 are typed in; the rest is checked by the model
		dir.push_back('{mk(ACT_POLL, 0, 0, 0, 0), 1, '0});
		dir.push_back('{mk(ACT_ERROR, 255, TMAX, 0, 1), 1, '0});
		dir.push_back('{mk(ACT_NONE, 0, 0, 1, 1), 1, '0});
		dir.push_back('{mk(ACT_ERROR, 0, 1000, 1, 0), 1, mk_status(1, 1, 1, 1, 1)});
		dir.push_back('{mk(ACT_ERROR, 0, 2000, 0, 0), 1, mk_status(1, 2, 1, 1, 1)});
		dir.push_back('{mk(ACT_POLL, 0, 63'd200000000, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_POLL, 0, 63'd250000000, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_IDR, 0, 63'd300000000, 0, 1), 0, '0});
		dir.push_back('{mk(ACT_IDR, 0, 63'd300000000, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_ERROR, 0, 63'd300000100, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_CLEAN, 0, 63'd400000000, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_CLEAN, 0, 63'd900000200, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_ERROR, 15, 63'd900000300, 1, 0), 0, '0});
		dir.push_back('{mk(ACT_FORCE_ALL, 0, 63'd1000000000, 1, 0), 0, '0});
		dir.push_back('{mk(ACT_IDR, 15, 63'd1100000000, 1, 0), 0, '0});
		dir.push_back('{mk(ACT_RESET_TILE, 15, 0, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_IDR, 16, TMAX, 1, 1), 0, '0});
		dir.push_back('{mk(ACT_CLEAN, 200, TMAX, 1, 1), 0, '0});
		dir.push_back('{mk(ACT_RESET_TILE, 255, TMAX, 1, 1), 0, '0});
		dir.push_back('{mk(ACT_POLL, 0, 63'd10, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_FORCE_ALL, 9, TMAX, 0, 1), 0, '0});
		dir.push_back('{mk(ACT_POLL, 3, TMAX, 1, 1), 0, '0});
		dir.push_back('{mk(ACT_CLEAN, 5, 0, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_RESET_ALL, 0, 0, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_POLL, 0, TMAX, 0, 0), 0, '0});

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir[i])
			send(dir[i].r, dir[i].typed, dir[i].e);
		random_phase(170, 64'h1FFF_FFFF);
		drain();

		write_reg(CFG_IDR_GRACE, 40'd50);
		write_reg(CFG_QUIET, 40'd100);
		write_reg(CFG_CAP, 40'd3);
		write_reg(CFG_INTERVAL, 40'd20);
		write_reg(CFG_SLOW_INTERVAL, 40'd200);
		random_phase(260, 64'h3F);
		drain();

		write_reg(CFG_IDR_GRACE, 40'd0);
		write_reg(CFG_QUIET, 40'd0);
		write_reg(CFG_CAP, 40'd0);
		write_reg(CFG_INTERVAL, 40'd0);
		write_reg(CFG_SLOW_INTERVAL, 40'd0);
		random_phase(170, 64'h7);
		drain();

		write_reg(CFG_IDR_GRACE, {CFG_DATA_W{1'b1}});
		write_reg(CFG_QUIET, {CFG_DATA_W{1'b1}});
		write_reg(CFG_CAP, 40'hFFFF);
		write_reg(CFG_INTERVAL, {CFG_DATA_W{1'b1}});
		write_reg(CFG_SLOW_INTERVAL, {CFG_DATA_W{1'b1}});
		random_phase(170, 64'h1FF_FFFF_FFFF);
		drain();

		write_reg(CFG_IDR_GRACE, 40'd5);
		write_reg(CFG_QUIET, 40'd30);
		write_reg(CFG_CAP, 40'd1);
		write_reg(CFG_INTERVAL, 40'd3);
		write_reg(CFG_SLOW_INTERVAL, 40'd40);
		random_phase(200, 64'h1F);
		drain();

		write_reg(CFG_IDR_GRACE, 40'd200000000);
		write_reg(CFG_QUIET, 40'd500000000);
		write_reg(CFG_CAP, 40'd5);
		write_reg(CFG_INTERVAL, 40'd100000000);
		write_reg(CFG_SLOW_INTERVAL, 40'd5000000000);
		random_phase(170, 64'h3FFF_FFFF);
		drain();

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
